// File: design/assert_macros.svh
// Assertion helpers for the edge filter RTL.
// Build with ASSERT_OFF defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: design/rgse_pkg.sv
`timescale 1ns / 1ps

package rgse_pkg;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd480;
    localparam logic [10:0] FRAME_MIN          = 11'd3;
    localparam logic [10:0] FRAME_HEIGHT_MAX   = 11'd1024;

    // Luma weights, sum is 64
    localparam logic [2:0] GRAY_WEIGHT_BLUE  = 3'd7;
    localparam logic [5:0] GRAY_WEIGHT_GREEN = 6'd38;
    localparam logic [4:0] GRAY_WEIGHT_RED   = 5'd19;
    localparam int         GRAY_SHIFT        = 6;

    localparam logic [7:0] MAG_MAX = 8'd255;

    // One column of the two stored lines
    typedef struct packed {
        logic [7:0] older;
        logic [7:0] newer;
    } line_pair_t;

    // Right-hand column of the 3x3 window
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } win_col_t;

    function automatic logic [7:0] rgb_to_gray(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        logic [13:0] acc;
        acc = 14'(b) * 14'(GRAY_WEIGHT_BLUE) + 14'(g) * 14'(GRAY_WEIGHT_GREEN)
            + 14'(r) * 14'(GRAY_WEIGHT_RED);
        return acc[GRAY_SHIFT +: 8];
    endfunction

endpackage

// File: design/rgb_gray_sobel_edge_filter_top.sv
`timescale 1ns / 1ps
// RGB to gray conversion with a 3x3 Sobel edge filter (L1 magnitude).
// Input channel s_*: one RGB pixel per item in raster order; s_frame_start
// marks the first pixel of a frame and zeroes the row and column counters.
// Output channel m_*: one item per interior centre pixel, issued once its
// bottom-right neighbour is accepted, with the centre row and column and a
// flag on the last interior result of the frame. Border pixels give none.
// Configuration: cfg_we writes frame_width (index 0) or frame_height
// (index 1); values are saturated to the legal range. Write only while idle.
// Throughput: one pixel per clock unless a held result stalls stage 1. The two
// previous rows live in a single dual-port RAM of MAX_WIDTH words; the read
// is issued as the pixel is accepted and the column is written back as stage 1
// moves on, with a bypass for a read of the column still being written.
// Pipeline: the RAM read and stage 1 registers take the bottom-right pixel as
// it is accepted, then the output register loads the result as stage 1 moves on.
// Reset: counters, window and output valid clear; register values return
// to 640 x 480. RAM content is undefined until the first rows are written.
// Stall: the output register holds while m_ready is low; the block keeps
// accepting pixels as long as the pipeline stage behind it can drain.
`include "assert_macros.svh"

module rgb_gray_sobel_edge_filter_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata,
    // pixel input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_red,
    input  logic        s_frame_start,
    // edge result
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_magnitude,
    output logic [9:0]  m_center_row,
    output logic [9:0]  m_center_col,
    output logic        m_frame_last
);
    import rgse_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int WCALC = (WW > 11) ? WW : 11;

    logic [10:0]    frame_width_reg, frame_height_reg;
    logic [AW-1:0]  col_reg, col_next;
    logic [9:0]     row_reg, row_next;

    logic [WCALC-1:0] width_cur, col_ext, col_inc;
    logic [10:0]      height_cur, row_inc;
    logic [AW-1:0]    col_cur;
    logic [9:0]       row_cur;
    logic             s_accept;
    logic             emit_cur, last_cur;
    logic [7:0]       gray_cur;

    logic             s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [7:0]       s1_gray_reg;
    logic [AW-1:0]    s1_col_reg;
    logic [9:0]       s1_row_reg;
    logic             s1_go;
    logic [WCALC-1:0] s1_col_dec;

    logic             m_valid_reg, m_frame_last_reg;
    logic [7:0]       m_magnitude_reg;
    logic [9:0]       m_center_row_reg, m_center_col_reg;

    line_pair_t       rd_pair, wr_pair;
    win_col_t         win_col;
    logic [7:0]       magnitude;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
            endcase
        end
    end

    // Saturate the frame size
    always_comb begin
        width_cur = WCALC'(frame_width_reg);
        if (width_cur < WCALC'(FRAME_MIN)) begin
            width_cur = WCALC'(FRAME_MIN);
        end else if (width_cur > WCALC'(MAX_WIDTH)) begin
            width_cur = WCALC'(MAX_WIDTH);
        end
        height_cur = frame_height_reg;
        if (height_cur < FRAME_MIN) begin
            height_cur = FRAME_MIN;
        end else if (height_cur > FRAME_HEIGHT_MAX) begin
            height_cur = FRAME_HEIGHT_MAX;
        end
    end

    // Position of the incoming pixel and raster advance
    always_comb begin
        col_cur  = s_frame_start ? '0 : col_reg;
        row_cur  = s_frame_start ? '0 : row_reg;
        col_ext  = WCALC'(col_cur);
        col_inc  = col_ext + WCALC'(1);
        row_inc  = 11'(row_cur) + 11'd1;
        emit_cur = (row_cur >= 10'd2) && (col_ext >= WCALC'(2));
        last_cur = (11'(row_cur) == height_cur - 11'd1)
                && (col_ext == width_cur - WCALC'(1));
        gray_cur = rgb_to_gray(s_blue, s_green, s_red);
        if (col_inc >= width_cur) begin
            col_next = '0;
            row_next = (row_inc >= height_cur) ? '0 : row_inc[9:0];
        end else begin
            col_next = col_inc[AW-1:0];
            row_next = row_cur;
        end
    end

    assign s1_go    = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_go;
    assign s_accept = s_valid && s_ready;

    // Advance the raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1 valid: RAM read in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_gray_reg <= gray_cur;
            s1_col_reg  <= col_cur;
            s1_row_reg  <= row_cur;
            s1_emit_reg <= emit_cur;
            s1_last_reg <= last_cur;
        end
    end

    // Shift both lines down by one row at the retiring column
    assign wr_pair.older = rd_pair.newer;
    assign wr_pair.newer = s1_gray_reg;

    rgse_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (col_cur),
        .rd_data (rd_pair),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (wr_pair)
    );

    assign win_col.top = rd_pair.older;
    assign win_col.mid = rd_pair.newer;
    assign win_col.bot = s1_gray_reg;

    rgse_kernel u_kernel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (s1_go),
        .col_in    (win_col),
        .magnitude (magnitude)
    );

    assign s1_col_dec = WCALC'(s1_col_reg) - WCALC'(1);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_emit_reg) begin
            m_magnitude_reg  <= magnitude;
            m_center_row_reg <= s1_row_reg - 10'd1;
            m_center_col_reg <= s1_col_dec[9:0];
            m_frame_last_reg <= s1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_magnitude  = m_magnitude_reg;
    assign m_center_row = m_center_row_reg;
    assign m_center_col = m_center_col_reg;
    assign m_frame_last = m_frame_last_reg;

    `ASSERT_CLK(a_empty_stage_ready, aclk, aresetn, !s1_valid_reg |-> s_ready, "stage empty but input stalled")
    `ASSERT_CLK(a_emit_loads_output, aclk, aresetn, s1_go && s1_emit_reg |=> m_valid_reg, "result dropped")
    `ASSERT_NEVER(a_center_row_border, aclk, aresetn, m_valid_reg && (m_center_row_reg == 10'd0), "border row emitted")
    `ASSERT_CLK(a_stall_holds_stage, aclk, aresetn, s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_col_reg), "stalled item lost")

endmodule

// File: design/rgse_line_store.sv
`timescale 1ns / 1ps

module rgse_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output rgse_pkg::line_pair_t    rd_data,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  rgse_pkg::line_pair_t    wr_data
);
    import rgse_pkg::*;

    line_pair_t mem [DEPTH];
    line_pair_t mem_q_reg;
    line_pair_t byp_data_reg;
    logic       byp_sel_reg;

    // Write the retiring column
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read on acceptance, hold while stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg    <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // Forward a write that lands on the address read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_sel_reg <= 1'b0;
        end else if (rd_en) begin
            byp_sel_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_sel_reg ? byp_data_reg : mem_q_reg;

endmodule

// File: design/rgse_kernel.sv
`timescale 1ns / 1ps

module rgse_kernel (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               shift_en,
    input  rgse_pkg::win_col_t col_in,
    output logic [7:0]         magnitude
);
    import rgse_pkg::*;

    logic [7:0] p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic [9:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic [9:0] gx_abs, gy_abs;
    logic [10:0] mag_sum;

    // Shift the window one column left as each item retires
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p00_reg <= '0;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= '0;
            p20_reg <= '0;
            p21_reg <= '0;
        end else if (shift_en) begin
            p00_reg <= p01_reg;
            p01_reg <= col_in.top;
            p10_reg <= p11_reg;
            p11_reg <= col_in.mid;
            p20_reg <= p21_reg;
            p21_reg <= col_in.bot;
        end
    end

    // Sobel sums, absolute values and clamp
    always_comb begin
        gx_pos = 10'(col_in.top) + {1'b0, col_in.mid, 1'b0} + 10'(col_in.bot);
        gx_neg = 10'(p00_reg) + {1'b0, p10_reg, 1'b0} + 10'(p20_reg);
        gy_pos = 10'(p20_reg) + {1'b0, p21_reg, 1'b0} + 10'(col_in.bot);
        gy_neg = 10'(p00_reg) + {1'b0, p01_reg, 1'b0} + 10'(col_in.top);
        gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
        gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
        mag_sum = 11'(gx_abs) + 11'(gy_abs);
        magnitude = (mag_sum > 11'(MAG_MAX)) ? MAG_MAX : mag_sum[7:0];
    end

endmodule
